// ===== sv/wrms_pkg.sv =====
// ----------------------------------------------------------------------------
// wrms_pkg
// shared constants, types and fsm encoding for the windowed rms meter
// ----------------------------------------------------------------------------
package wrms_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_W           = 12;
  localparam int SUM_W           = 36;
  localparam int FRAC_W          = 16;
  localparam int QUO_W           = SUM_W + FRAC_W;
  localparam int ROOT_W          = QUO_W / 2;
  localparam int SREM_W          = ROOT_W + 2;
  localparam int RMS_W           = 20;
  localparam int DIV_STEPS       = QUO_W;
  localparam int SQRT_STEPS      = ROOT_W;
  localparam int CNT_W           = $clog2(DIV_STEPS);
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 12'd2400;
  localparam logic [CFG_W-1:0] STEP_RESET   = 12'd1000;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  localparam logic [2:0] COLOR_OFF   = 3'b000;
  localparam logic [2:0] COLOR_RED   = 3'b001;
  localparam logic [2:0] COLOR_GREEN = 3'b010;
  localparam logic [2:0] COLOR_ALL   = 3'b111;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } wrms_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_step;
    logic emit;
  } wrms_cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } wrms_sts_t;

endpackage

// ===== sv/wrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrms_ctrl
// sequencer: square, accumulate, then serial divide and root on window close
// ----------------------------------------------------------------------------
module wrms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wrms_pkg::wrms_sts_t sts,
  output wrms_pkg::wrms_cmd_t cmd
);
  import wrms_pkg::*;

  wrms_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_last, sqrt_last;

  assign div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sqrt_last = (cnt_r == CNT_W'(SQRT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: state_nxt = ST_ACCUM;
      ST_ACCUM: begin
        state_nxt = sts.close ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_last) state_nxt = ST_SQRT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_SQRT: begin
        if (sqrt_last) state_nxt = ST_EMIT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQUARE: cmd.square    = 1'b1;
      ST_ACCUM:  cmd.accum     = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_SQRT:   cmd.sqrt_step = 1'b1;
      ST_EMIT:   cmd.emit      = sts.out_free;
      default:   cmd           = '0;
    endcase
  end

endmodule

// ===== sv/wrms_dp.sv =====
// ----------------------------------------------------------------------------
// wrms_dp
// datapath: square, saturating sum, colour bands, restoring divide and root
// ----------------------------------------------------------------------------
module wrms_dp #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [wrms_pkg::CFG_W-1:0]  window_length,
  input  logic [wrms_pkg::CFG_W-1:0]  band_step,
  input  wrms_pkg::wrms_cmd_t         cmd,
  output wrms_pkg::wrms_sts_t         sts,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        out_heartbeat,
  output logic                        out_red_on,
  output logic                        out_green_on,
  output logic                        out_blue_on,
  output logic                        out_rms_valid,
  output logic [wrms_pkg::RMS_W-1:0]  out_rms_value
);
  import wrms_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int CMP_W = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 3;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SQ_W-1:0]        square_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CFG_W-1:0]       count_r;
  logic                   toggle_r;
  logic [2:0]             color_r;
  logic                   close_r;
  logic [QUO_W-1:0]       quo_r;
  logic [CFG_W-1:0]       drem_r;
  logic [SREM_W-1:0]      srem_r;
  logic [ROOT_W-1:0]      root_r;

  logic                   out_valid_r;
  logic                   out_heartbeat_r, out_red_r, out_green_r, out_blue_r;
  logic                   out_rms_valid_r;
  logic [RMS_W-1:0]       out_rms_r;

  logic [CFG_W-1:0]       n_eff, step_eff;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_sat;
  logic [CFG_W-1:0]       count_inc;
  logic                   close;
  logic [CMP_W-1:0]       s_ext, m1, m2, m3, m5;
  logic [2:0]             color_nxt;
  logic [CFG_W:0]         d_trial, d_div, d_diff;
  logic                   d_ge;
  logic [SREM_W+1:0]      s_trial, s_test, s_diff;
  logic                   s_ge;
  logic [RMS_W-1:0]       rms_sat;

  always_comb begin
    n_eff    = (window_length == '0) ? CFG_W'(1) : window_length;
    step_eff = (band_step == '0) ? CFG_W'(1) : band_step;

    sum_add   = {1'b0, sum_r} + (SUM_W + 1)'(square_r);
    sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    count_inc = count_r + 1'b1;
    close     = (count_inc == '0) || (count_inc >= n_eff);

    // band edges at one, two, three and five steps
    s_ext = CMP_W'(sample_r);
    m1    = CMP_W'(step_eff);
    m2    = m1 << 1;
    m3    = m1 + m2;
    m5    = (m1 << 2) + m1;
    if (s_ext < m1)      color_nxt = COLOR_OFF;
    else if (s_ext < m2) color_nxt = COLOR_RED;
    else if (s_ext < m3) color_nxt = COLOR_GREEN;
    else if (s_ext < m5) color_nxt = COLOR_ALL;
    else                 color_nxt = color_r;

    // one quotient bit per step
    d_trial = {drem_r, quo_r[QUO_W-1]};
    d_div   = {1'b0, n_eff};
    d_ge    = (d_trial >= d_div);
    d_diff  = d_trial - d_div;

    // one root bit per step
    s_trial = {srem_r, quo_r[QUO_W-1 -: 2]};
    s_test  = {2'b00, root_r, 2'b01};
    s_ge    = (s_trial >= s_test);
    s_diff  = s_trial - s_test;

    rms_sat = (|root_r[ROOT_W-1:RMS_W]) ? '1 : root_r[RMS_W-1:0];

    sts.close    = close;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      count_r  <= '0;
      toggle_r <= 1'b0;
      color_r  <= COLOR_OFF;
    end else if (cmd.accum) begin
      toggle_r <= !toggle_r;
      color_r  <= color_nxt;
      if (close) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_sat;
        count_r <= count_inc;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= in_sample;
    if (cmd.square) square_r <= SQ_W'(sample_r) * SQ_W'(sample_r);
    if (cmd.accum) begin
      close_r <= close;
      quo_r   <= {sum_sat, {FRAC_W{1'b0}}};
      drem_r  <= '0;
      srem_r  <= '0;
      root_r  <= '0;
    end
    if (cmd.div_step) begin
      quo_r  <= {quo_r[QUO_W-2:0], d_ge};
      drem_r <= d_ge ? d_diff[CFG_W-1:0] : d_trial[CFG_W-1:0];
    end
    if (cmd.sqrt_step) begin
      quo_r  <= quo_r << 2;
      srem_r <= s_ge ? s_diff[SREM_W-1:0] : s_trial[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], s_ge};
    end
    if (cmd.emit) begin
      out_heartbeat_r <= toggle_r;
      out_red_r       <= color_r[0];
      out_green_r     <= color_r[1];
      out_blue_r      <= color_r[2];
      out_rms_valid_r <= close_r;
      out_rms_r       <= close_r ? rms_sat : '0;
    end
  end

  // output word holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_heartbeat = out_heartbeat_r;
  assign out_red_on    = out_red_r;
  assign out_green_on  = out_green_r;
  assign out_blue_on   = out_blue_r;
  assign out_rms_valid = out_rms_valid_r;
  assign out_rms_value = out_rms_r;

endmodule

// ===== sv/windowed_rms_with_level_bands_top.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_with_level_bands_top - windowed rms meter with level bands
// a word is taken in idle, squared, accumulated, then emitted once the output register is free;
// a word that closes a window also passes the divide (52 steps) and root (26 steps) states
// of the serial divider and square root unit; the next sample is taken after the emit
// reset (synchronous, rst_n low): sum, count, heartbeat and colour cleared, regs to defaults
// ----------------------------------------------------------------------------
module windowed_rms_with_level_bands_top #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_heartbeat,
  output logic                         out_red_on,
  output logic                         out_green_on,
  output logic                         out_blue_on,
  output logic                         out_rms_valid,
  output logic [wrms_pkg::RMS_W-1:0]   out_rms_value,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrms_pkg::ADDR_W-1:0]  paddr,
  input  logic [wrms_pkg::DATA_W-1:0]  pwdata,
  output logic [wrms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import wrms_pkg::*;

  // configuration registers; the user must write them only while the meter is idle, the block does not enforce it
  logic [CFG_W-1:0] window_length_r;
  logic [CFG_W-1:0] band_step_r;
  logic             reg_wr;

  wrms_cmd_t cmd;
  wrms_sts_t sts;

  // no wait states on the register port
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  // register select by word address, byte lanes ignored; upper data bits dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
      band_step_r     <= STEP_RESET;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_WINDOW: window_length_r <= pwdata[CFG_W-1:0];
        REG_STEP:   band_step_r     <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (paddr[2])
      REG_WINDOW: prdata = DATA_W'(window_length_r);
      REG_STEP:   prdata = DATA_W'(band_step_r);
      default:    prdata = '0;
    endcase
  end

  // sequencer: one word in flight; a finished word parks in the output
  // register so the next sample can be taken while it waits
  wrms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic: squarer, saturating 36-bit sum, band compare,
  // bit-serial restoring divide of sum*65536 by the window length,
  // then bit-serial square root of the quotient, saturated to 12.8
  wrms_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_sample),
    .window_length (window_length_r),
    .band_step     (band_step_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_heartbeat (out_heartbeat),
    .out_red_on    (out_red_on),
    .out_green_on  (out_green_on),
    .out_blue_on   (out_blue_on),
    .out_rms_valid (out_rms_valid),
    .out_rms_value (out_rms_value)
  );

endmodule

// ===== test/tb_windowed_rms_with_level_bands_top.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rms_with_level_bands_top - self-checking bench for the rms meter
// drives converter sample words through the valid/stall channel and sets the
// window and band registers over the apb port between phases. a behavioural
// predictor tracks sum, count, heartbeat and colour and queues one expected
// result word per accepted sample. every result word is checked field by
// field against the oldest queued word. a typed-in table covers the extremes
// and corner cases first. bursty random traffic follows under random
// receiver stalls, with one long receiver hold-off to back up the input side
// ----------------------------------------------------------------------------
module tb_windowed_rms_with_level_bands_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wrms_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int RAND_ITEMS   = 600;
  localparam int DRAIN_CYCLES = 100;      // idle wait after the expected queue empties
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_NS     = 1_000_000;
  localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};
  localparam logic [RMS_W-1:0] RMS_CAP = {RMS_W{1'b1}};

  // one result word as the block presents it
  typedef struct packed {
    logic             heartbeat;
    logic             red_on;
    logic             green_on;
    logic             blue_on;
    logic             rms_valid;
    logic [RMS_W-1:0] rms_value;
  } rms_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  // one line of the directed plan: a sample word or a register write
  typedef struct packed {
    row_kind_t              kind;
    logic                   reg_idx;
    logic [DATA_W-1:0]      wdata;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   typed;    // expected word given in the row itself
    rms_word_t              want;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  // typed rows are read straight off the band rules with the reset registers
  // (window 2400, band step 1000); the rest go through the predictor
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // first word after reset, band zero, heartbeat goes high
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd0,    1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0}},
    // full scale lands in band four, all on
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 20'd0}},
    // just under the first band edge
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd999,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0}},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd1000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 20'd0}},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd2000, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 20'd0}},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd3000, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 20'd0}},
    // window cut to 3 with six samples already counted, junk in the upper bits
    '{ROW_WRITE,  REG_WINDOW, 32'hFFFF_F003, 12'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd7,    1'b0, '0},
    // zero band step behaves as one
    '{ROW_WRITE,  REG_STEP,   32'h0001_0000, 12'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd0,    1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd1,    1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd2,    1'b0, '0},
    // bands above four keep the colour they found
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd5,    1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    // zero window behaves as one, every word closes
    '{ROW_WRITE,  REG_WINDOW, 32'hABCD_E000, 12'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd0,    1'b0, '0},
    // widest window and widest band step
    '{ROW_WRITE,  REG_WINDOW, 32'h0000_0FFF, 12'd0, 1'b0, '0},
    '{ROW_WRITE,  REG_STEP,   32'hFFFF_FFFF, 12'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    // window cut to one with three full-scale words counted: the close saturates the rms
    '{ROW_WRITE,  REG_WINDOW, 32'h0000_0001, 12'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, REG_WINDOW, 32'h0, 12'd4094, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_heartbeat;
  logic                   out_red_on;
  logic                   out_green_on;
  logic                   out_blue_on;
  logic                   out_rms_valid;
  logic [RMS_W-1:0]       out_rms_value;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // predictor copy of the registers and state
  logic [CFG_W-1:0] win_len;
  logic [CFG_W-1:0] band_w;
  logic [SUM_W-1:0] sq_sum;
  logic [CFG_W-1:0] win_cnt;
  logic             beat;
  logic [2:0]       colour;

  rms_word_t pending_words [$];
  rms_word_t got_word;
  rms_word_t want_word;

  int fault_count;
  int samples_sent;
  int windows_seen;
  int writes_done;
  int hold_ask;
  int hold_done;

  windowed_rms_with_level_bands_top u_top (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_sample,
    .out_valid,
    .out_stall,
    .out_heartbeat,
    .out_red_on,
    .out_green_on,
    .out_blue_on,
    .out_rms_valid,
    .out_rms_value,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // next result word for one sample, state advanced as the block would
  function automatic rms_word_t meter_predict(input logic [SAMPLE_BITS-1:0] s);
    rms_word_t        r;
    logic [SUM_W:0]   grown;
    logic [CFG_W-1:0] span;
    logic [CFG_W-1:0] step;
    logic [63:0]      rest;
    logic [63:0]      root;
    logic [63:0]      probe;
    int unsigned      band;
    span = (win_len == '0) ? CFG_W'(1) : win_len;
    step = (band_w == '0) ? CFG_W'(1) : band_w;
    r = '0;
    beat = ~beat;
    grown = (SUM_W+1)'(sq_sum) + (SUM_W+1)'(s) * (SUM_W+1)'(s);
    sq_sum = (grown > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP : grown[SUM_W-1:0];
    win_cnt = win_cnt + 1'b1;
    // close once the count reaches the window now in force, or on wrap
    if (win_cnt >= span || win_cnt == '0) begin
      rest = (64'(sq_sum) << FRAC_W) / 64'(span);
      // bitwise integer square root
      root = '0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != '0) begin
        if (rest >= root + probe) begin
          rest = rest - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      r.rms_valid = 1'b1;
      r.rms_value = (root > 64'(RMS_CAP)) ? RMS_CAP : root[RMS_W-1:0];
      sq_sum = '0;
      win_cnt = '0;
    end
    band = 32'(s) / 32'(step);
    if (band == 0) begin
      colour = COLOR_OFF;
    end else if (band == 1) begin
      colour = COLOR_RED;
    end else if (band == 2) begin
      colour = COLOR_GREEN;
    end else if (band <= 4) begin
      colour = COLOR_ALL;
    end
    r.heartbeat = beat;
    r.red_on    = colour[0];
    r.green_on  = colour[1];
    r.blue_on   = colour[2];
    return r;
  endfunction

  // offer one sample word and hold it until the block takes it
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s, input logic typed,
                              input rms_word_t typed_word);
    rms_word_t predicted;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = meter_predict(s);
    pending_words.push_back(typed ? typed_word : predicted);
    samples_sent++;
  endtask

  // register access with the block idle: optional write, then read back
  task automatic access_reg(input logic idx, input logic do_write,
                            input logic [DATA_W-1:0] wdata);
    logic [CFG_W-1:0] model_val;
    @(negedge clk) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (do_write) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clk) penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (idx == REG_WINDOW) begin
        win_len = wdata[CFG_W-1:0];
      end else begin
        band_w = wdata[CFG_W-1:0];
      end
      writes_done++;
    end
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_val = (idx == REG_WINDOW) ? win_len : band_w;
    if (prdata !== DATA_W'(model_val)) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
        $display("read back of register %0d: expected %0d, got %0d", idx, model_val, prdata);
      end
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_word = '{out_heartbeat, out_red_on, out_green_on, out_blue_on,
                   out_rms_valid, out_rms_value};
      if (pending_words.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("result word with nothing expected: hb %b rgb %b%b%b rms %b/%0d",
                   got_word.heartbeat, got_word.red_on, got_word.green_on,
                   got_word.blue_on, got_word.rms_valid, got_word.rms_value);
        end
      end else begin
        want_word = pending_words.pop_front();
        if (got_word !== want_word) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display({"word mismatch: hb %b/%b red %b/%b green %b/%b blue %b/%b",
                      " valid %b/%b rms %0d/%0d"},
                     want_word.heartbeat, got_word.heartbeat,
                     want_word.red_on, got_word.red_on,
                     want_word.green_on, got_word.green_on,
                     want_word.blue_on, got_word.blue_on,
                     want_word.rms_valid, got_word.rms_valid,
                     want_word.rms_value, got_word.rms_value);
          end
        end
        if (got_word.rms_valid) windows_seen++;
      end
    end
  end

  // receiver: its own stall pattern, plus the long hold-off when asked
  initial begin : stall_gen
    stall_mode_t mode;
    int          mode_left;
    int          tick;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 30;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_done) begin
        // back the block up so the input side has to stall
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      tick++;
      case (mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_stall <= ((tick % 5) < 2);
        end
      endcase
    end
  end

  // overall run limit
  initial begin : run_limit
    #(LIMIT_NS);
    $display("timed out with %0d result words outstanding", pending_words.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    logic [CFG_W-1:0]       win_val;
    logic [CFG_W-1:0]       step_val;
    logic [DATA_W-1:0]      wdata;
    logic [SAMPLE_BITS-1:0] s;
    int                     rand_items;
    int                     phase_no;
    int                     phase_len;
    int                     burst_left;
    int unsigned            eff;
    int unsigned            base;

    // every input known from time zero
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    hold_ask  = 0;
    hold_done = 0;
    fault_count  = 0;
    samples_sent = 0;
    windows_seen = 0;
    writes_done  = 0;

    // predictor reset state
    win_len = WINDOW_RESET;
    band_w  = STEP_RESET;
    sq_sum  = '0;
    win_cnt = '0;
    beat    = 1'b0;
    colour  = COLOR_OFF;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // register defaults after reset
    access_reg(REG_WINDOW, 1'b0, '0);
    access_reg(REG_STEP, 1'b0, '0);

    // directed plan, back to back
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        access_reg(PLAN[i].reg_idx, 1'b1, PLAN[i].wdata);
      end else begin
        offer_sample(PLAN[i].sample, PLAN[i].typed, PLAN[i].want);
      end
    end

    // random phases, each with fresh window and band settings
    rand_items = 0;
    phase_no   = 0;
    burst_left = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       win_val = '0;
        1:       win_val = CFG_W'(1);
        2:       win_val = '1;
        default: win_val = CFG_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       step_val = '0;
        1:       step_val = CFG_W'(1);
        2:       step_val = '1;
        default: step_val = CFG_W'($urandom_range(200, 1300));
      endcase
      // upper register bits carry junk that must be dropped
      wdata = $urandom;
      wdata[CFG_W-1:0] = win_val;
      access_reg(REG_WINDOW, 1'b1, wdata);
      wdata = $urandom;
      wdata[CFG_W-1:0] = step_val;
      access_reg(REG_STEP, 1'b1, wdata);

      if (phase_no == 2) hold_ask++;

      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        // bursts of words with idle gaps between them
        if (burst_left == 0) begin
          @(negedge clk) in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if ($urandom_range(0, 3) == 0) begin
          s = SAMPLE_BITS'($urandom);
        end else begin
          // aim at a colour band, including the ones that hold the colour
          eff  = (band_w == '0) ? 1 : band_w;
          base = $urandom_range(0, 6) * eff + $urandom_range(0, eff - 1);
          s = (base > (2**SAMPLE_BITS - 1)) ? SAMPLE_BITS'($urandom) : SAMPLE_BITS'(base);
        end
        offer_sample(s, 1'b0, '0);
        rand_items++;
      end
      phase_no++;
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d sample words (%0d plan rows) over %0d random phases, %0d windows closed",
             samples_sent, PLAN_ROWS, phase_no, windows_seen);
    $display("%0d register writes, %0d long receiver hold-off(s), %0d failures",
             writes_done, hold_done, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
